/* rtl/u2wa_pkg.sv */
package u2wa_pkg;

   localparam int ByteWidth = 8;
   localparam int CodeWidth = 16;

   typedef enum logic [1:0] {
      ST_CHAR  = 2'd0,
      ST_ERROR = 2'd1,
      ST_END   = 2'd2
   } status_type;

   typedef struct packed {
      logic [CodeWidth-1:0] partial_code;
      logic [1:0]           bytes_pending;
      logic [1:0]           sequence_length;
      logic                 error_seen;
   } dec_state_type;

   typedef struct packed {
      logic                 valid;
      logic [ByteWidth-1:0] out_byte;
      status_type           status;
   } dec_result_type;

   typedef struct packed {
      logic                 ok;
      logic [ByteWidth-1:0] out_byte;
   } map_type;

   function automatic map_type map_code(input logic [CodeWidth-1:0] cp);
      map_type m;
      m.ok       = 1'b1;
      m.out_byte = cp[ByteWidth-1:0];
      if (cp <= 16'h007f || (cp >= 16'h00a0 && cp <= 16'h00ff)) begin
         m.ok = 1'b1;
      end else begin
         case (cp)
            16'h20ac: m.out_byte = 8'h80;
            16'h201a: m.out_byte = 8'h82;
            16'h0192: m.out_byte = 8'h83;
            16'h201e: m.out_byte = 8'h84;
            16'h2026: m.out_byte = 8'h85;
            16'h2020: m.out_byte = 8'h86;
            16'h2021: m.out_byte = 8'h87;
            16'h02c6: m.out_byte = 8'h88;
            16'h2030: m.out_byte = 8'h89;
            16'h0160: m.out_byte = 8'h8a;
            16'h2039: m.out_byte = 8'h8b;
            16'h0152: m.out_byte = 8'h8c;
            16'h017d: m.out_byte = 8'h8e;
            16'h2018: m.out_byte = 8'h91;
            16'h2019: m.out_byte = 8'h92;
            16'h201c: m.out_byte = 8'h93;
            16'h201d: m.out_byte = 8'h94;
            16'h2022: m.out_byte = 8'h95;
            16'h2013: m.out_byte = 8'h96;
            16'h2014: m.out_byte = 8'h97;
            16'h02dc: m.out_byte = 8'h98;
            16'h2122: m.out_byte = 8'h99;
            16'h0161: m.out_byte = 8'h9a;
            16'h203a: m.out_byte = 8'h9b;
            16'h0153: m.out_byte = 8'h9c;
            16'h017e: m.out_byte = 8'h9e;
            16'h0178: m.out_byte = 8'h9f;
            default: begin
               m.ok       = 1'b0;
               m.out_byte = '0;
            end
         endcase
      end
      return m;
   endfunction

endpackage

/* rtl/u2wa_step.sv */
module u2wa_step (
   input  logic [u2wa_pkg::ByteWidth-1:0] in_byte,
   input  u2wa_pkg::dec_state_type        cur,
   output u2wa_pkg::dec_state_type        nxt,
   output u2wa_pkg::dec_result_type       res
);

   logic [u2wa_pkg::CodeWidth-1:0] shifted;
   logic [1:0]                     pend_dec;
   u2wa_pkg::map_type              mapped;
   logic                           bad_range;

   assign shifted  = {cur.partial_code[u2wa_pkg::CodeWidth-7:0], in_byte[5:0]};
   assign pend_dec = cur.bytes_pending - 2'd1;
   assign mapped   = u2wa_pkg::map_code(shifted);
   assign bad_range = (cur.sequence_length == 2'd2 && shifted < 16'h0080) ||
                      (cur.sequence_length == 2'd3 && shifted < 16'h0800) ||
                      (shifted >= 16'hd800 && shifted <= 16'hdfff);

   always_comb begin
      nxt          = cur;
      res.valid    = 1'b0;
      res.out_byte = '0;
      res.status   = u2wa_pkg::ST_CHAR;
      if (in_byte == '0) begin
         nxt        = '0;
         res.valid  = !cur.error_seen;
         res.status = (cur.bytes_pending != 2'd0) ? u2wa_pkg::ST_ERROR : u2wa_pkg::ST_END;
      end else if (!cur.error_seen) begin
         if (cur.bytes_pending == 2'd0) begin
            if (in_byte < 8'h80) begin
               res.valid    = 1'b1;
               res.out_byte = in_byte;
            end else if (in_byte >= 8'hc2 && in_byte <= 8'hdf) begin
               nxt.partial_code    = {11'd0, in_byte[4:0]};
               nxt.bytes_pending   = 2'd1;
               nxt.sequence_length = 2'd2;
            end else if (in_byte >= 8'he0 && in_byte <= 8'hef) begin
               nxt.partial_code    = {12'd0, in_byte[3:0]};
               nxt.bytes_pending   = 2'd2;
               nxt.sequence_length = 2'd3;
            end else begin
               nxt            = '0;
               nxt.error_seen = 1'b1;
               res.valid      = 1'b1;
               res.status     = u2wa_pkg::ST_ERROR;
            end
         end else if (in_byte[7:6] != 2'b10) begin
            nxt            = '0;
            nxt.error_seen = 1'b1;
            res.valid      = 1'b1;
            res.status     = u2wa_pkg::ST_ERROR;
         end else if (pend_dec != 2'd0) begin
            nxt.partial_code  = shifted;
            nxt.bytes_pending = pend_dec;
         end else if (bad_range || !mapped.ok) begin
            nxt            = '0;
            nxt.error_seen = 1'b1;
            res.valid      = 1'b1;
            res.status     = u2wa_pkg::ST_ERROR;
         end else begin
            nxt          = '0;
            res.valid    = 1'b1;
            res.out_byte = mapped.out_byte;
         end
      end
   end

endmodule

/* rtl/utf8_to_winansi_transcoder_core.sv */
// UTF-8 to WinAnsi (Windows-1252) transcoder.
// Input channel req_: one UTF-8 byte per item on req_in_byte; a zero byte
// ends the text. Output channel rsp_: zero or one result item per input
// item, rsp_out_byte with rsp_status (0 character, 1 format error, 2 end).
// An input byte is decoded in the cycle it is accepted; its result, if any,
// is valid on rsp_ in the next cycle. Throughput is one item per cycle while
// the receiver does not stall, set by the single decode step between the
// state registers and the result register.
// The first error in a text gives one error item; later bytes give nothing
// until the zero terminator, which clears the decode state.
// When the receiver stalls, the held result stays in the output register and
// req_ready drops until it is taken; a byte that gives no result is still
// taken only when the output register can accept a new one.
// Synchronous active-high reset clears the decode state and the output
// valid; the block accepts items in the first cycle after reset.
module utf8_to_winansi_transcoder_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [u2wa_pkg::ByteWidth-1:0] req_in_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [u2wa_pkg::ByteWidth-1:0] rsp_out_byte,
   output logic [1:0]                     rsp_status
);

   u2wa_pkg::dec_state_type  state_ff, state_in;
   u2wa_pkg::dec_result_type res;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [u2wa_pkg::ByteWidth-1:0] rsp_byte_ff, rsp_byte_in;
   u2wa_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic                     accept;

   u2wa_step u_step (
      .in_byte (req_in_byte),
      .cur     (state_ff),
      .nxt     (state_in),
      .res     (res)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      if (accept && res.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = res.out_byte;
         rsp_status_in = res.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

/* tb/utf8_to_winansi_transcoder_core_tb.sv */
module utf8_to_winansi_transcoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]           in_byte;
      logic                 typed;
      logic                 yields;
      logic [7:0]           out_byte;
      u2wa_pkg::status_type status;
   } stim_row_type;

   typedef struct packed {
      logic [7:0]           out_byte;
      u2wa_pkg::status_type status;
   } winansi_result_type;

   localparam logic [26:0][15:0] SPECIAL_CODES = {
      16'h20ac, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
      16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017d, 16'h2018,
      16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014, 16'h02dc,
      16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h017e, 16'h0178};
   localparam logic [26:0][7:0] SPECIAL_BYTES = {
      8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
      8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8c, 8'h8e, 8'h91,
      8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
      8'h99, 8'h9a, 8'h9b, 8'h9c, 8'h9e, 8'h9f};

   localparam int RandomItems = 1100;
   localparam int HoldCycles  = 80;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;

   // predictor state
   logic [15:0] dec_code = '0;
   logic [1:0]  dec_pending = '0;
   logic [1:0]  dec_len = '0;
   logic        dec_err = 1'b0;

   stim_row_type       offered_q[$];
   winansi_result_type expect_q[$];
   int  mismatches = 0;
   int  sent_count = 0;
   bit  busy_phase = 1'b0;
   bit  hold_rsp_req = 1'b0;

   // typed == 0: expectation taken from the predictor
   stim_row_type directed_rows [0:27] = '{
      '{8'h00, 1'b1, 1'b1, 8'h00, u2wa_pkg::ST_END},
      '{8'h01, 1'b1, 1'b1, 8'h01, u2wa_pkg::ST_CHAR},
      '{8'h7f, 1'b1, 1'b1, 8'h7f, u2wa_pkg::ST_CHAR},
      '{8'hc3, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'hbf, 1'b0, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'he2, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'h82, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'hac, 1'b0, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'he0, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'h9f, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'hbf, 1'b0, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'h41, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'h00, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'hed, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'ha0, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'h80, 1'b0, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'h00, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'hc2, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'h41, 1'b1, 1'b1, 8'h00, u2wa_pkg::ST_ERROR},
      '{8'h00, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'hff, 1'b1, 1'b1, 8'h00, u2wa_pkg::ST_ERROR},
      '{8'h00, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'he2, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'h82, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'h00, 1'b1, 1'b1, 8'h00, u2wa_pkg::ST_ERROR},
      '{8'hc2, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'h80, 1'b0, 1'b0, 8'h00, u2wa_pkg::ST_CHAR},
      '{8'h00, 1'b1, 1'b0, 8'h00, u2wa_pkg::ST_CHAR}};

   utf8_to_winansi_transcoder_core uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("utf8_to_winansi_transcoder_core test failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] %s", $time, what);
   endtask

   function automatic bit winansi_lookup(input logic [15:0] cp, output logic [7:0] ob);
      ob = 8'h00;
      if (cp <= 16'h007f || (cp >= 16'h00a0 && cp <= 16'h00ff)) begin
         ob = cp[7:0];
         return 1'b1;
      end
      for (int i = 0; i < 27; i++) begin
         if (SPECIAL_CODES[i] == cp) begin
            ob = SPECIAL_BYTES[i];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit flag_error(output u2wa_pkg::status_type st);
      dec_code = '0;
      dec_pending = '0;
      dec_len = '0;
      dec_err = 1'b1;
      st = u2wa_pkg::ST_ERROR;
      return 1'b1;
   endfunction

   function automatic bit predict_winansi(input logic [7:0] b, output logic [7:0] ob,
                                          output u2wa_pkg::status_type st);
      logic [15:0] cp;
      bit was_err;
      bit mid;
      ob = 8'h00;
      st = u2wa_pkg::ST_CHAR;
      if (b == 8'h00) begin
         was_err = dec_err;
         mid = (dec_pending != 2'd0);
         dec_code = '0;
         dec_pending = '0;
         dec_len = '0;
         dec_err = 1'b0;
         if (was_err) return 1'b0;
         st = mid ? u2wa_pkg::ST_ERROR : u2wa_pkg::ST_END;
         return 1'b1;
      end
      if (dec_err) return 1'b0;
      if (dec_pending == 2'd0) begin
         if (b < 8'h80) begin
            ob = b;
            return 1'b1;
         end
         if (b >= 8'hc2 && b <= 8'hdf) begin
            dec_code = {11'd0, b[4:0]};
            dec_pending = 2'd1;
            dec_len = 2'd2;
            return 1'b0;
         end
         if (b >= 8'he0 && b <= 8'hef) begin
            dec_code = {12'd0, b[3:0]};
            dec_pending = 2'd2;
            dec_len = 2'd3;
            return 1'b0;
         end
         return flag_error(st);
      end
      if (b[7:6] != 2'b10) return flag_error(st);
      dec_code = {dec_code[9:0], b[5:0]};
      dec_pending = dec_pending - 2'd1;
      if (dec_pending != 2'd0) return 1'b0;
      cp = dec_code;
      if ((dec_len == 2'd2 && cp < 16'h0080) || (dec_len == 2'd3 && cp < 16'h0800) ||
          (cp >= 16'hd800 && cp <= 16'hdfff))
         return flag_error(st);
      if (!winansi_lookup(cp, ob)) return flag_error(st);
      dec_code = '0;
      dec_pending = '0;
      dec_len = '0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      winansi_result_type want;
      winansi_result_type pred;
      stim_row_type row;
      logic [7:0] ob;
      u2wa_pkg::status_type st;
      bit yields;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expect_q.size() == 0) begin
               report_mismatch($sformatf("unexpected item: byte %h status %0d",
                                         rsp_out_byte, rsp_status));
            end else begin
               want = expect_q.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %h, want %h",
                                            rsp_out_byte, want.out_byte));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_status, want.status));
            end
         end
         if (req_valid && req_ready) begin
            row = offered_q.pop_front();
            yields = predict_winansi(req_in_byte, ob, st);
            if (row.typed) begin
               yields = row.yields;
               ob = row.out_byte;
               st = row.status;
            end
            if (yields) begin
               pred.out_byte = ob;
               pred.status   = st;
               expect_q.insert(expect_q.size(), pred);
            end
         end
      end
   end

   // receiver side
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            rsp_ready <= busy_phase || ($urandom_range(99) >= 22);
            @(posedge clock);
         end
      end
   end

   task automatic send_row(input stim_row_type row);
      while (!busy_phase && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= row.in_byte;
      offered_q.insert(offered_q.size(), row);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      stim_row_type row;
      row = '0;
      row.in_byte = b;
      send_row(row);
   endtask

   task automatic send_code(input logic [15:0] cp);
      if (cp < 16'h0800) begin
         send_byte({3'b110, cp[10:6]});
      end else begin
         send_byte({4'b1110, cp[15:12]});
         send_byte({2'b10, cp[11:6]});
      end
      send_byte({2'b10, cp[5:0]});
   endtask

   task automatic send_text();
      int n;
      int sel;
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 40) begin
            send_byte(8'($urandom_range(8'h7f, 8'h01)));
         end else if (sel < 55) begin
            send_code(16'($urandom_range(8'hff, 8'ha0)));
         end else if (sel < 70) begin
            send_code(SPECIAL_CODES[$urandom_range(26)]);
         end else if (sel < 78) begin
            send_byte(8'($urandom_range(8'hdf, 8'hc2)));
            send_byte(8'($urandom_range(8'hbf, 8'h80)));
         end else if (sel < 90) begin
            send_byte(8'($urandom_range(8'hef, 8'he0)));
            send_byte(8'($urandom_range(8'hbf, 8'h80)));
            send_byte(8'($urandom_range(8'hbf, 8'h80)));
         end else begin
            send_byte(8'($urandom_range(8'hff, 8'h01)));
         end
      end
      // lead byte, sometimes with one continuation; may cut the text off inside a sequence
      if ($urandom_range(99) < 8) begin
         send_byte(8'($urandom_range(8'hef, 8'hc2)));
         if ($urandom_range(1)) send_byte(8'($urandom_range(8'hbf, 8'h80)));
      end
      send_byte(8'h00);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (expect_q.size() != 0 || offered_q.size() != 0);
   endtask

   // sender side
   initial begin
      bit hold_done;
      bit pause_done;
      hold_done = 1'b0;
      pause_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      foreach (directed_rows[i]) send_row(directed_rows[i]);
      while (sent_count < RandomItems + 28) begin
         if (!hold_done && sent_count >= 300) begin
            hold_done = 1'b1;
            hold_rsp_req = 1'b1;
         end
         if (!pause_done && sent_count >= 600) begin
            pause_done = 1'b1;
            drain_results();
         end
         busy_phase = (sent_count >= 700 && sent_count < 900);
         send_text();
      end
      busy_phase = 1'b0;
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("utf8_to_winansi_transcoder_core test passed");
      end else begin
         $display("utf8_to_winansi_transcoder_core test failed");
      end
      $finish;
   end

endmodule

/* utf8_to_winansi_transcoder_core.f */
rtl/u2wa_pkg.sv
rtl/u2wa_step.sv
rtl/utf8_to_winansi_transcoder_core.sv
tb/utf8_to_winansi_transcoder_core_tb.sv
